// ===== rtl/xmodem_packet_receiver_assert.svh =====
// Assertion macros shared by the XMODEM packet receiver checker.
`ifndef XMODEM_PACKET_RECEIVER_ASSERT_SVH
`define XMODEM_PACKET_RECEIVER_ASSERT_SVH

// Property checked only while the block is out of reset.
`define XPR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("xmodem receiver assertion failed");

// Property checked at every edge, reset included.
`define XPR_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("xmodem receiver assertion failed");

`endif

// ===== rtl/xpr_pkg.sv =====
// Package with the payload types and register indexes of the XMODEM packet receiver.
package xpr_pkg;

  // Configuration register indexes.
  localparam logic [7:0] CFG_START_CODE = 8'd0;
  localparam logic [7:0] CFG_END_CODE   = 8'd1;

  // Reset values of the configuration registers (SOH and EOT).
  localparam logic [7:0] START_CODE_RST = 8'd1;
  localparam logic [7:0] END_CODE_RST   = 8'd4;

  // Block number plus its complement must sum to this value.
  localparam logic [8:0] COMPL_SUM = 9'd255;

  typedef struct packed {
    logic [7:0] rx_byte;
  } xpr_in_t;

  typedef struct packed {
    logic       store_valid;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic       header_ok;
    logic [7:0] block_number;
    logic       header_error;
    logic       packet_done;
    logic       start_seen;
    logic       end_seen;
  } xpr_out_t;

  typedef struct packed {
    logic [7:0] reg_index;
    logic [7:0] wdata;
  } xpr_cfg_t;

endpackage

// ===== rtl/xpr_stream_if.sv =====
// Valid/ready channel interface carrying one request payload.
interface xpr_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/xmodem_packet_receiver.sv =====
// XMODEM packet receiver: one received byte in, one framing result out, every cycle while the output is not stalled.
// Each accepted byte yields exactly one result request, in order. A byte goes into an
// input register, the framing state machine decodes it against the current phase, and
// the result lands in an output register, so a new byte can be taken every cycle while
// the output is not stalled (one byte per cycle sustained). While a result waits on a stalled
// output, the input register takes at most one more byte and then the input stalls too.
// Payload and CRC bytes come out as
// buffer writes at indices 0 to PAYLOAD_BYTES+1 (low 8 bits), with pulses for a start
// byte, an end-of-transfer byte, a good or bad block number and a finished packet. The
// CRC is not checked. Write start_code and end_code only while the block is idle.
module xmodem_packet_receiver
  import xpr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 128
) (
  input  logic          clk,
  input  logic          rst_n,
  xpr_stream_if.sink    in_ch,
  xpr_stream_if.source  out_ch,
  xpr_stream_if.sink    cfg_ch
);

  localparam int CW = $clog2(PAYLOAD_BYTES + 2);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BLOCK = 3'd1,
    PH_COMPL = 3'd2,
    PH_FIRST = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRC1  = 3'd5,
    PH_CRC2  = 3'd6
  } phase_t;

  // Configuration registers.
  logic [7:0] start_code_r;
  logic [7:0] end_code_r;

  // Input register.
  logic       in_valid_r;
  logic [7:0] rx_r;

  // Framing state.
  phase_t     phase_r, phase_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] count_inc;
  logic [7:0] held_r, held_nxt;

  // Output register.
  logic       out_valid_r;
  xpr_out_t   res_r, res_nxt;

  logic       advance;
  logic       fire;
  logic [8:0] compl_sum;
  logic [CW+7:0] idx_ext;

  // Handshake: the output register frees when empty or taken, the input register follows.
  assign advance      = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !in_valid_r || advance;
  assign fire         = in_valid_r && advance;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.payload = res_r;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r <= START_CODE_RST;
      end_code_r   <= END_CODE_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.payload.reg_index)
        CFG_START_CODE: start_code_r <= cfg_ch.payload.wdata;
        CFG_END_CODE:   end_code_r   <= cfg_ch.payload.wdata;
        default: ;
      endcase
    end
  end

  // Input register valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Input register payload.
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      rx_r <= in_ch.payload.rx_byte;
    end
  end

  assign count_inc = count_r + CW'(1);
  assign compl_sum = {1'b0, rx_r} + {1'b0, held_r};
  assign idx_ext   = {8'b0, count_r};

  // Per-byte framing decode.
  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    res_nxt   = '0;
    case (phase_r)
      PH_IDLE: begin
        count_nxt = '0;
        if (rx_r == start_code_r) begin
          phase_nxt          = PH_BLOCK;
          res_nxt.start_seen = 1'b1;
        end
        if (rx_r == end_code_r) begin
          res_nxt.end_seen = 1'b1;
        end
      end
      PH_BLOCK: begin
        held_nxt  = rx_r;
        phase_nxt = PH_COMPL;
      end
      PH_COMPL: begin
        if (compl_sum == COMPL_SUM) begin
          res_nxt.header_ok    = 1'b1;
          res_nxt.block_number = held_r;
          phase_nxt            = PH_FIRST;
        end else begin
          res_nxt.header_error = 1'b1;
          phase_nxt            = PH_IDLE;
        end
      end
      PH_FIRST: begin
        res_nxt.store_valid = 1'b1;
        res_nxt.store_index = 8'd0;
        res_nxt.store_byte  = rx_r;
        count_nxt           = CW'(1);
        phase_nxt           = (PAYLOAD_BYTES <= 1) ? PH_CRC1 : PH_DATA;
      end
      PH_DATA: begin
        res_nxt.store_valid = 1'b1;
        res_nxt.store_index = idx_ext[7:0];
        res_nxt.store_byte  = rx_r;
        count_nxt           = count_inc;
        if (count_inc >= CW'(PAYLOAD_BYTES)) begin
          phase_nxt = PH_CRC1;
        end
      end
      PH_CRC1: begin
        res_nxt.store_valid = 1'b1;
        res_nxt.store_index = idx_ext[7:0];
        res_nxt.store_byte  = rx_r;
        count_nxt           = count_inc;
        phase_nxt           = PH_CRC2;
      end
      PH_CRC2: begin
        res_nxt.store_valid = 1'b1;
        res_nxt.store_index = idx_ext[7:0];
        res_nxt.store_byte  = rx_r;
        res_nxt.packet_done = 1'b1;
        count_nxt           = count_inc;
        phase_nxt           = PH_IDLE;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Framing state and output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (fire) begin
        phase_r <= phase_nxt;
        count_r <= count_nxt;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
      end
    end
  end

  // Held block number and result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      held_r <= held_nxt;
      res_r  <= res_nxt;
    end
  end

endmodule

// ===== rtl/xpr_checker.sv =====
// Port-level checker for the XMODEM packet receiver, with its bind statement.
`include "xmodem_packet_receiver_assert.svh"

module xpr_checker
  import xpr_pkg::*;
#(
  parameter int PAYLOAD_BYTES = 128
) (
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input xpr_out_t out_payload
);

  localparam logic [7:0] LAST_INDEX = 8'((PAYLOAD_BYTES + 1) % 256);

  // No result appears in the cycle after reset.
  `XPR_ASSERT_ALWAYS(a_no_result_after_reset, clk, !rst_n |=> !out_valid)

  // A stalled result holds.
  `XPR_ASSERT(a_result_holds, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_payload))

  // The input side keeps taking requests while the output is free.
  `XPR_ASSERT(a_ready_when_free, clk, rst_n, !out_valid |-> in_ready)

  // A finished packet ends on the second CRC byte.
  `XPR_ASSERT(a_done_on_last, clk, rst_n,
    out_valid && out_payload.packet_done |->
      out_payload.store_valid && out_payload.store_index == LAST_INDEX)

  // Header pulses exclude stores and each other.
  `XPR_ASSERT(a_header_exclusive, clk, rst_n,
    out_valid && (out_payload.header_ok || out_payload.header_error) |->
      !out_payload.store_valid && !(out_payload.header_ok && out_payload.header_error))

endmodule

bind xmodem_packet_receiver xpr_checker #(
  .PAYLOAD_BYTES (PAYLOAD_BYTES)
) u_xpr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_payload (out_ch.payload)
);

// ===== dv/tb_xmodem_packet_receiver.sv =====
// Self-checking testbench for the XMODEM packet receiver with a framing scoreboard.
`timescale 1ns / 1ps

module tb_xmodem_packet_receiver;
  import xpr_pkg::*;

  localparam int          PAYLOAD_BYTES    = 128;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam int          LONG_HOLD_CYCLES = 400;
  localparam int          DRAIN_CYCLES     = 4;
  localparam logic [7:0]  CFG_UNUSED_IDX   = 8'd7;

  // Framing phases of the parser.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BLOCK = 3'd1,
    PH_COMPL = 3'd2,
    PH_FIRST = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRC1  = 3'd5,
    PH_CRC2  = 3'd6
  } frame_phase_t;

  // Tracks the framing state, predicts one result per byte and checks results in order.
  class frame_scoreboard;
    logic [7:0]   start_code;
    logic [7:0]   end_code;
    frame_phase_t phase;
    int unsigned  byte_count;
    logic [7:0]   held_block;
    xpr_out_t     pending_frames[$];
    int           errors;

    function new();
      start_code = START_CODE_RST;
      end_code   = END_CODE_RST;
      phase      = PH_IDLE;
      byte_count = 0;
      held_block = '0;
      errors     = 0;
    endfunction

    function void write_reg(logic [7:0] idx, logic [7:0] value);
      if (idx == CFG_START_CODE) begin
        start_code = value;
      end else if (idx == CFG_END_CODE) begin
        end_code = value;
      end
    endfunction

    // Advances the parser by one accepted byte and queues the result it causes.
    function void note_byte(logic [7:0] b);
      xpr_out_t r;
      r = '0;
      case (phase)
        PH_IDLE: begin
          byte_count = 0;
          if (b == start_code) begin
            phase        = PH_BLOCK;
            r.start_seen = 1'b1;
          end
          if (b == end_code) begin
            r.end_seen = 1'b1;
          end
        end
        PH_BLOCK: begin
          held_block = b;
          phase      = PH_COMPL;
        end
        PH_COMPL: begin
          // The sum is taken at nine bits, so it must be exactly 255.
          if ({1'b0, b} + {1'b0, held_block} == COMPL_SUM) begin
            r.header_ok    = 1'b1;
            r.block_number = held_block;
            phase          = PH_FIRST;
          end else begin
            r.header_error = 1'b1;
            phase          = PH_IDLE;
          end
        end
        PH_FIRST: begin
          r.store_valid = 1'b1;
          r.store_index = 8'd0;
          r.store_byte  = b;
          byte_count    = 1;
          phase         = (byte_count >= PAYLOAD_BYTES) ? PH_CRC1 : PH_DATA;
        end
        PH_DATA: begin
          r.store_valid = 1'b1;
          r.store_index = byte_count[7:0];
          r.store_byte  = b;
          byte_count    = (byte_count + 1) & 32'h7FF;
          if (byte_count >= PAYLOAD_BYTES) begin
            phase = PH_CRC1;
          end
        end
        PH_CRC1: begin
          r.store_valid = 1'b1;
          r.store_index = byte_count[7:0];
          r.store_byte  = b;
          byte_count    = (byte_count + 1) & 32'h7FF;
          phase         = PH_CRC2;
        end
        PH_CRC2: begin
          r.store_valid = 1'b1;
          r.store_index = byte_count[7:0];
          r.store_byte  = b;
          byte_count    = (byte_count + 1) & 32'h7FF;
          r.packet_done = 1'b1;
          phase         = PH_IDLE;
        end
        default: begin
          phase = PH_IDLE;
        end
      endcase
      pending_frames.push_back(r);
    endfunction

    function void check_field(string name, int unsigned exp_val, int unsigned act_val);
      if (exp_val != act_val) begin
        $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
        errors++;
      end
    endfunction

    // Compares an accepted result with the oldest prediction, field by field.
    function void check_result(xpr_out_t got);
      xpr_out_t exp_r;
      if (pending_frames.size() == 0) begin
        $error("result request arrived with no prediction waiting");
        errors++;
        return;
      end
      exp_r = pending_frames.pop_front();
      check_field("store_valid", exp_r.store_valid, got.store_valid);
      check_field("store_index", exp_r.store_index, got.store_index);
      check_field("store_byte", exp_r.store_byte, got.store_byte);
      check_field("header_ok", exp_r.header_ok, got.header_ok);
      check_field("block_number", exp_r.block_number, got.block_number);
      check_field("header_error", exp_r.header_error, got.header_error);
      check_field("packet_done", exp_r.packet_done, got.packet_done);
      check_field("start_seen", exp_r.start_seen, got.start_seen);
      check_field("end_seen", exp_r.end_seen, got.end_seen);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  xpr_stream_if #(.payload_t(xpr_in_t))  in_ch();
  xpr_stream_if #(.payload_t(xpr_out_t)) out_ch();
  xpr_stream_if #(.payload_t(xpr_cfg_t)) cfg_ch();

  xmodem_packet_receiver #(.PAYLOAD_BYTES(PAYLOAD_BYTES)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  frame_scoreboard sb;
  int              cycle_count;
  int              burst_left;
  int              bytes_sent;
  bit              hold_request;
  bit              hold_done;

  // Clock with a 2 ns period.
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // All inputs start at known values.
  initial begin
    sb             = new();
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.payload  = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.payload = '0;
    out_ch.ready   = 1'b0;
    cycle_count    = 0;
    burst_left     = 0;
    bytes_sent     = 0;
    hold_request   = 1'b0;
    hold_done      = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("xmodem_packet_receiver: mismatch");
      $finish;
    end
  end

  // Monitors for accepted byte, configuration and result requests.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_byte(in_ch.payload.rx_byte);
    end
    if (rst_n && cfg_ch.valid && cfg_ch.ready) begin
      sb.write_reg(cfg_ch.payload.reg_index, cfg_ch.payload.wdata);
    end
    if (rst_n && out_ch.valid && out_ch.ready) begin
      sb.check_result(out_ch.payload);
    end
  end

  // Result sink: stalls on a changing pattern, with one long hold-off on request.
  initial begin : result_sink
    int mode;
    int span;
    int tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 128);
      repeat (span) begin
        @(posedge clk);
        tick++;
        if (hold_request && !hold_done) begin
          out_ch.ready <= 1'b0;
          repeat (LONG_HOLD_CYCLES) @(posedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 1) == 1);
          2: out_ch.ready <= ($urandom_range(0, 3) == 0);
          default: out_ch.ready <= (tick % 5 != 0);
        endcase
      end
    end
  end

  // Offers one byte, with bursts and random gaps, and waits until it is taken.
  task automatic send_byte(input logic [7:0] b);
    if (burst_left == 0) begin
      if ($urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(100, 300);
      end else begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
    end
    burst_left--;
    in_ch.valid           <= 1'b1;
    in_ch.payload.rx_byte <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bytes_sent++;
  endtask

  // Stops offering bytes and waits until every predicted result has arrived.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write, after which the configuration channel goes idle.
  task automatic write_register(input logic [7:0] idx, input logic [7:0] value);
    cfg_ch.valid             <= 1'b1;
    cfg_ch.payload.reg_index <= idx;
    cfg_ch.payload.wdata     <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sends a packet body: payload bytes and the two CRC bytes.
  task automatic send_body(input bit extremes);
    for (int i = 0; i < PAYLOAD_BYTES + 2; i++) begin
      if (extremes) begin
        send_byte((i % 2 == 0) ? 8'h00 : 8'hFF);
      end else begin
        send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Mostly well-formed packets with random content, mixed with noise and bad headers.
  task automatic send_traffic(input int n_bytes);
    int         start_mark;
    int         len;
    logic [7:0] blk;
    logic [7:0] cmp;
    start_mark = bytes_sent;
    while (bytes_sent - start_mark < n_bytes) begin
      if ($urandom_range(0, 99) < 70) begin
        blk = 8'($urandom_range(0, 255));
        cmp = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 255)) : ~blk;
        send_byte(sb.start_code);
        send_byte(blk);
        send_byte(cmp);
        // A bad header is sometimes followed by its body anyway.
        if (cmp == ~blk || $urandom_range(0, 2) == 0) begin
          send_body(1'b0);
        end
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) begin
          case ($urandom_range(0, 3))
            0: send_byte(sb.end_code);
            1: send_byte(8'h00);
            2: send_byte(8'hFF);
            default: send_byte(8'($urandom_range(0, 255)));
          endcase
        end
      end
    end
  endtask

  // One configuration setting followed by random traffic.
  task automatic run_setting(input logic [7:0] sc, input logic [7:0] ec, input int n_bytes);
    wait_drained();
    write_register(CFG_START_CODE, sc);
    write_register(CFG_END_CODE, ec);
    send_traffic(n_bytes);
  endtask

  // Main sequence.
  initial begin : stimulus
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Directed part at reset codes: end byte, extremes, bad and good headers.
    send_byte(END_CODE_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(START_CODE_RST);
    send_byte(8'h80);
    send_byte(8'h80);
    send_byte(START_CODE_RST);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // The start byte as block number is not a new start.
    send_byte(START_CODE_RST);
    send_byte(START_CODE_RST);
    send_byte(8'hFE);
    send_body(1'b1);
    send_byte(START_CODE_RST);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_body(1'b1);

    // Random traffic at reset codes, with the long receiver hold-off.
    hold_request = 1'b1;
    send_traffic(100);

    // An unused register index must leave the codes alone.
    wait_drained();
    write_register(CFG_UNUSED_IDX, 8'h99);
    send_traffic(40);

    run_setting(8'h00, 8'hFF, 100);
    run_setting(8'hFF, 8'h00, 100);
    // Start code equal to end code.
    run_setting(8'h5A, 8'h5A, 100);
    run_setting(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 100);

    wait_drained();
    if (sb.errors == 0 && sb.pending_frames.size() == 0) begin
      $display("xmodem_packet_receiver: match");
    end else begin
      $display("xmodem_packet_receiver: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/xpr_pkg.sv
rtl/xpr_stream_if.sv
rtl/xmodem_packet_receiver.sv
rtl/xpr_checker.sv
dv/tb_xmodem_packet_receiver.sv
